@@ rtl/core/dvtp_pkg.sv @@
// Shared types and constants of the display vblank time predictor.
package dvtp_pkg;

  // Field widths.
  localparam int unsigned PERIOD_W = 15;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned COUNT_W  = 32;

  // Configuration port geometry: two 64-bit registers at 8-byte spacing.
  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned APB_ADDR_W = 4;
  localparam logic        REG_PERIOD = 1'b0;
  localparam logic        REG_SAMPLE = 1'b1;

  // Period limits in microseconds.
  localparam logic [PERIOD_W-1:0] PERIOD_DEFAULT = 15'd16667;
  localparam logic [PERIOD_W-1:0] EST_MIN        = 15'd10000;
  localparam logic [PERIOD_W-1:0] EST_MAX        = 15'd25000;
  localparam logic [PERIOD_W-1:0] OVR_MIN        = 15'd10000;
  localparam logic [PERIOD_W-1:0] OVR_MAX        = 15'd30000;

  // Divider: one quotient bit per cycle.
  localparam int unsigned DIV_STEPS = TIME_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Where the display time came from.
  typedef enum logic [1:0] {
    SRC_WALL   = 2'd0,
    SRC_SAMPLE = 2'd1,
    SRC_VBLANK = 2'd2
  } dvtp_src_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXTEND,
    ST_DEFAULT,
    ST_SAMPLE,
    ST_VBCHK,
    ST_DIVIDE,
    ST_EST,
    ST_PREDICT,
    ST_PCHECK,
    ST_FINISH
  } dvtp_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic extend;
    logic set_default;
    logic sample;
    logic div_start;
    logic store_prev;
    logic est_update;
    logic predict;
    logic pcheck;
    logic load_out;
  } dvtp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sample_set;
    logic vb_known;
    logic est_ok;
    logic div_done;
    logic out_busy;
  } dvtp_status_t;

endpackage

@@ rtl/core/dvtp_if.sv @@
// Valid/ready channel interfaces for query items and result items.
interface dvtp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] raw_time;
  logic [63:0] vblank_time;
  logic [31:0] vblank_cnt;

  modport source (output valid, output raw_time, output vblank_time, output vblank_cnt,
                  input ready);
  modport sink (input valid, input raw_time, input vblank_time, input vblank_cnt,
                output ready);
endinterface

interface dvtp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] display_time;
  logic [1:0]  time_source;

  modport source (output valid, output display_time, output time_source, input ready);
  modport sink (input valid, input display_time, input time_source, output ready);
endinterface

@@ rtl/core/dvtp_cfg.sv @@
// APB-style configuration registers of the predictor.
module dvtp_cfg
  import dvtp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [PERIOD_W-1:0]   period_o,
  output logic [TIME_W-1:0]     sample_time_o
);

  logic [PERIOD_W-1:0] period_q, period_d;
  logic [TIME_W-1:0]   sample_q, sample_d;
  logic                wr_en;
  logic [PERIOD_W-1:0] wr_period;
  logic                period_legal;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // An override is taken only if it is zero or lies in the legal range.
  assign wr_period    = pwdata[PERIOD_W-1:0];
  assign period_legal = (wr_period == '0) || ((wr_period >= OVR_MIN) && (wr_period <= OVR_MAX));

  always_comb begin
    period_d = period_q;
    sample_d = sample_q;
    if (wr_en) begin
      unique case (paddr[3])
        REG_PERIOD: if (period_legal) period_d = wr_period;
        REG_SAMPLE: sample_d = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= '0;
      sample_q <= '0;
    end else begin
      period_q <= period_d;
      sample_q <= sample_d;
    end
  end

  // Read back.
  always_comb begin
    unique case (paddr[3])
      REG_PERIOD: prdata = APB_DATA_W'(period_q);
      REG_SAMPLE: prdata = sample_q;
      default:    prdata = '0;
    endcase
  end

  assign period_o      = period_q;
  assign sample_time_o = sample_q;

endmodule

@@ rtl/core/dvtp_div.sv @@
// Restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module dvtp_div
  import dvtp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [TIME_W-1:0]  dividend_i,
  input  logic [COUNT_W-1:0] divisor_i,
  output logic               done_o,
  output logic [TIME_W-1:0]  quotient_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [TIME_W-1:0]    dq_q, dq_d;
  logic [COUNT_W-1:0]   rem_q, rem_d;
  logic [COUNT_W-1:0]   dvs_q, dvs_d;
  logic [COUNT_W:0]     rem_sh;
  logic [COUNT_W:0]     rem_sub;
  logic                 fits;

  // One step: shift in the next dividend bit and subtract if it fits.
  assign rem_sh  = {rem_q, dq_q[TIME_W-1]};
  assign fits    = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      dq_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      dq_d  = {dq_q[TIME_W-2:0], fits};
      rem_d = fits ? rem_sub[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

@@ rtl/core/dvtp_datapath.sv @@
// Datapath: time extension, period estimate, prediction and result register.
module dvtp_datapath
  import dvtp_pkg::*;
#(
  parameter int unsigned RAW_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dvtp_cmd_t          cmd_i,
  output dvtp_status_t       status_o,
  input  logic [PERIOD_W-1:0] period_cfg_i,
  input  logic [TIME_W-1:0]  sample_time_i,
  input  logic [31:0]        raw_time_i,
  input  logic [TIME_W-1:0]  vblank_time_i,
  input  logic [COUNT_W-1:0] vblank_cnt_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [TIME_W-1:0]  display_time_o,
  output logic [1:0]         time_source_o
);

  // Captured query.
  logic [RAW_WIDTH-1:0] raw_q;
  logic [TIME_W-1:0]    vt_q;
  logic [COUNT_W-1:0]   vc_q;

  // Persistent state.
  logic                 base_valid_q;
  logic [RAW_WIDTH-1:0] time_base_q;
  logic [RAW_WIDTH-1:0] last_raw_q;
  logic [COUNT_W-1:0]   wrap_q;
  logic [PERIOD_W-1:0]  est_q;
  logic [TIME_W-1:0]    prev_vt_q;
  logic [COUNT_W-1:0]   prev_vc_q;

  // Working registers.
  logic [TIME_W-1:0]    now_q;
  logic [TIME_W-1:0]    disp_q;
  dvtp_src_e            src_q;
  logic [TIME_W-1:0]    pred_q;

  // Result register.
  logic                 out_valid_q;
  logic [TIME_W-1:0]    out_time_q;
  dvtp_src_e            out_src_q;

  logic [COUNT_W-1:0]   wrap_nx;
  logic [TIME_W-1:0]    base_ext;
  logic [TIME_W-1:0]    div_dividend;
  logic [COUNT_W-1:0]   div_divisor;
  logic                 div_done;
  logic [TIME_W-1:0]    quotient;
  logic                 q_in_range;
  logic [PERIOD_W-1:0]  period_sel;
  logic                 sample_ok;

  assign base_ext = TIME_W'(time_base_q);

  // A reading below the previous one means the counter wrapped.
  assign wrap_nx = (base_valid_q && (raw_q < last_raw_q)) ? wrap_q + 1'b1 : wrap_q;

  // Estimate operands and range check of the quotient.
  assign div_dividend = vt_q - prev_vt_q;
  assign div_divisor  = vc_q - prev_vc_q;
  assign q_in_range   = (quotient[TIME_W-1:PERIOD_W] == '0) &&
                        (quotient[PERIOD_W-1:0] >= EST_MIN) &&
                        (quotient[PERIOD_W-1:0] <= EST_MAX);

  assign period_sel = (period_cfg_i != '0) ? period_cfg_i : est_q;
  assign sample_ok  = (sample_time_i > base_ext) && (sample_time_i <= now_q);

  dvtp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Status toward the controller.
  assign status_o.sample_set = sample_time_i != '0;
  assign status_o.vb_known   = (vt_q != '0) && (vc_q != '0);
  assign status_o.est_ok     = (prev_vt_q != '0) && (vc_q != prev_vc_q) && (vt_q > prev_vt_q);
  assign status_o.div_done   = div_done;
  assign status_o.out_busy   = out_valid_q && !out_ready_i;

  // Control-type state with reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_valid_q <= 1'b0;
      time_base_q  <= '0;
      last_raw_q   <= '0;
      wrap_q       <= '0;
      est_q        <= PERIOD_DEFAULT;
      prev_vt_q    <= '0;
      prev_vc_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.extend) begin
        if (!base_valid_q) begin
          base_valid_q <= 1'b1;
          time_base_q  <= raw_q;
        end
        wrap_q     <= wrap_nx;
        last_raw_q <= raw_q;
      end
      if (cmd_i.store_prev) begin
        prev_vt_q <= vt_q;
        prev_vc_q <= vc_q;
      end
      if (cmd_i.est_update && q_in_range) begin
        est_q <= quotient[PERIOD_W-1:0];
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      raw_q <= raw_time_i[RAW_WIDTH-1:0];
      vt_q  <= vblank_time_i;
      vc_q  <= vblank_cnt_i;
    end
    if (cmd_i.extend) begin
      now_q <= (TIME_W'(wrap_nx) << RAW_WIDTH) | TIME_W'(raw_q);
    end
    if (cmd_i.set_default) begin
      disp_q <= now_q - TIME_W'(base_valid_q ? time_base_q : raw_q);
      src_q  <= SRC_WALL;
    end
    if (cmd_i.sample && sample_ok) begin
      disp_q <= sample_time_i - base_ext;
      src_q  <= SRC_SAMPLE;
    end
    if (cmd_i.predict) begin
      pred_q <= vt_q + TIME_W'(period_sel);
    end
    if (cmd_i.pcheck && (pred_q > base_ext)) begin
      disp_q <= pred_q - base_ext;
      src_q  <= SRC_VBLANK;
    end
    if (cmd_i.load_out) begin
      out_time_q <= disp_q;
      out_src_q  <= src_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign display_time_o = out_time_q;
  assign time_source_o  = out_src_q;

endmodule

@@ rtl/core/dvtp_ctrl.sv @@
// Controller state machine that sequences one query item through the datapath.
module dvtp_ctrl
  import dvtp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  dvtp_status_t status_i,
  output dvtp_cmd_t    cmd_o
);

  dvtp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_EXTEND;
      ST_EXTEND:  state_d = ST_DEFAULT;
      ST_DEFAULT: begin
        priority if (status_i.sample_set) state_d = ST_SAMPLE;
        else if (status_i.vb_known)      state_d = ST_VBCHK;
        else                             state_d = ST_FINISH;
      end
      ST_SAMPLE:  state_d = ST_FINISH;
      ST_VBCHK:   state_d = status_i.est_ok ? ST_DIVIDE : ST_PREDICT;
      ST_DIVIDE:  if (status_i.div_done) state_d = ST_EST;
      ST_EST:     state_d = ST_PREDICT;
      ST_PREDICT: state_d = ST_PCHECK;
      ST_PCHECK:  state_d = ST_FINISH;
      ST_FINISH:  if (!status_i.out_busy) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_EXTEND:  cmd_o.extend      = 1'b1;
      ST_DEFAULT: cmd_o.set_default = 1'b1;
      ST_SAMPLE:  cmd_o.sample      = 1'b1;
      ST_VBCHK: begin
        cmd_o.store_prev = 1'b1;
        cmd_o.div_start  = status_i.est_ok;
      end
      ST_DIVIDE:  ;
      ST_EST:     cmd_o.est_update  = 1'b1;
      ST_PREDICT: cmd_o.predict     = 1'b1;
      ST_PCHECK:  cmd_o.pcheck      = 1'b1;
      ST_FINISH:  cmd_o.load_out    = !status_i.out_busy;
      default:    ;
    endcase
  end

endmodule

@@ rtl/core/display_vblank_time_predictor_core.sv @@
// Top level of the display vblank time predictor.
//
// Query items arrive on in_if (raw microsecond reading, latest vblank time
// and count); one result item per query leaves on out_if (display time
// relative to the time base, and its source code). Both channels use
// valid/ready and an item moves when both are high.
// Two registers sit on the APB-style port: the period override at byte 0
// and the frame sample time at byte 8; pready is always high.
// One query is handled at a time. An accepted query is extended to the
// full time and given the clock-reading answer, which a frame sample or a
// vblank prediction may then replace; one that computes a new estimate
// first waits for the divider, which produces one quotient bit per cycle.
// The next query is taken in the cycle after the result is loaded.
// The result sits in an output register; while it waits for the receiver
// the next query can be accepted and worked on, and it stalls only in
// its last step until the output register is free.
// Reset clears the configuration registers, the time base, wrap count and vblank
// history, and sets the period estimate to 16667 us.
module display_vblank_time_predictor_core
  import dvtp_pkg::*;
#(
  parameter int unsigned RAW_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  dvtp_in_if.sink               in_if,
  dvtp_out_if.source            out_if,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  dvtp_cmd_t           cmd;
  dvtp_status_t        status;
  logic [PERIOD_W-1:0] period_cfg;
  logic [TIME_W-1:0]   sample_time;

  dvtp_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .period_o      (period_cfg),
    .sample_time_o (sample_time)
  );

  dvtp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dvtp_datapath #(
    .RAW_WIDTH (RAW_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .period_cfg_i   (period_cfg),
    .sample_time_i  (sample_time),
    .raw_time_i     (in_if.raw_time),
    .vblank_time_i  (in_if.vblank_time),
    .vblank_cnt_i   (in_if.vblank_cnt),
    .out_valid_o    (out_if.valid),
    .out_ready_i    (out_if.ready),
    .display_time_o (out_if.display_time),
    .time_source_o  (out_if.time_source)
  );

  // Only one query is in flight at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("query accepted while another was in flight");

  // A frame-sample result requires a configured sample time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && (out_if.time_source == SRC_SAMPLE) |-> sample_time != '0)
    else $error("frame-sample result without a sample time");

  // A vblank prediction is only made when no sample time is configured.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && (out_if.time_source == SRC_VBLANK) |-> sample_time == '0)
    else $error("vblank prediction while a sample time is set");

endmodule
